/* design/bfss_pkg.sv */
// Package for the three-hash Bloom filter over byte strings.
// Holds sizes, hash start values, the job type and the back-end state type.
// No dependencies.
package bfss_pkg;

    // Filter size in bits (power of two) and the derived bit-position width
    localparam int FILTER_BITS = 16384;
    localparam int BIT_W       = $clog2(FILTER_BITS);

    // Bit store organized as rows of 32-bit words
    localparam int WORD_W = 32;
    localparam int COL_W  = $clog2(WORD_W);
    localparam int ROWS   = FILTER_BITS / WORD_W;
    localparam int ROW_W  = BIT_W - COL_W;

    // Hash constants
    localparam logic [31:0] RS_STEP   = 32'd378551;
    localparam logic [31:0] RS_START  = 32'd63689;
    localparam logic [31:0] JS_START  = 32'd1315423911;
    localparam logic [31:0] PJW_TOP   = 32'hF000_0000;
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

    // Job queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    // Operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Number of hash positions per string and their index width
    localparam int NUM_HASH = 3;
    localparam int IDX_W    = 2;
    localparam logic [IDX_W-1:0] IDX_RS  = 2'd0;
    localparam logic [IDX_W-1:0] IDX_JS  = 2'd1;
    localparam logic [IDX_W-1:0] IDX_PJW = 2'd2;

    typedef logic [BIT_W-1:0] t_pos;

    // One finished string: operation and the three selected bit positions
    typedef struct packed {
        logic                      cmd;
        logic [NUM_HASH-1:0][BIT_W-1:0] pos;
    } t_job;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_back_state;

endpackage

/* design/bfss_if.sv */
// Valid/ready channel interfaces for the Bloom filter block.
// Input carries string bytes, output carries one result per string.
// No dependencies.
interface bfss_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output cmd, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input cmd, input data_byte, input last_byte,
                    output ready);
endinterface

interface bfss_out_if;
    logic valid;
    logic ready;
    logic was_query;
    logic found;

    modport source (output valid, output was_query, output found, input ready);
    modport sink   (input valid, input was_query, input found, output ready);
endinterface

/* design/bfss_front.sv */
// Front end: runs the RS, JS and PJW hashes one byte per cycle unless stalled
// by i_in.ready, and queues a job with the three bit positions per final byte.
// Depends on bfss_pkg and bfss_in_if.
module bfss_front
    import bfss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfss_in_if.sink    i_in,
    input  t_q_stat    i_q_stat,
    input  t_back_stat i_back_stat,
    output logic       o_push,
    output t_job       o_job
);

    // RS only needs the low bits: the product's low bits depend on low bits only
    logic [BIT_W-1:0]   r_rs_acc, n_rs_acc;
    logic [BIT_W-1:0]   r_rs_mul, n_rs_mul;
    logic [31:0]        r_js, n_js;
    logic [31:0]        r_pjw, n_pjw;

    logic [2*BIT_W-1:0] w_rs_prod;
    logic [2*BIT_W-1:0] w_rs_step;
    logic [31:0]        w_byte32;
    logic [31:0]        w_pjw_sh;
    logic               w_accept;

    // Take bytes while the queue has room and the store is not being cleared
    assign i_in.ready = !i_q_stat.full && !i_back_stat.clearing;
    assign w_accept   = i_in.valid && i_in.ready;

    // Hash step
    always_comb begin
        w_byte32  = {24'd0, i_in.data_byte};
        w_rs_prod = r_rs_acc * r_rs_mul;
        w_rs_step = r_rs_mul * RS_STEP[BIT_W-1:0];
        n_rs_acc  = w_rs_prod[BIT_W-1:0] + t_pos'(i_in.data_byte);
        n_rs_mul  = w_rs_step[BIT_W-1:0];

        n_js = r_js ^ ((r_js << 5) + w_byte32 + (r_js >> 2));

        w_pjw_sh = (r_pjw << 4) + w_byte32;
        if ((w_pjw_sh & PJW_TOP) != 32'd0) begin
            n_pjw = (w_pjw_sh ^ {24'd0, w_pjw_sh[31:28], 4'd0}) & (WORD_MASK ^ PJW_TOP);
        end else begin
            n_pjw = w_pjw_sh;
        end
    end

    // Job for the back end, built from the finished hashes
    always_comb begin
        o_push             = w_accept && i_in.last_byte;
        o_job.cmd          = i_in.cmd;
        o_job.pos[IDX_RS]  = n_rs_acc;
        o_job.pos[IDX_JS]  = n_js[BIT_W-1:0];
        o_job.pos[IDX_PJW] = n_pjw[BIT_W-1:0];
    end

    // Hash state, restarted after every string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_acc <= '0;
            r_rs_mul <= RS_START[BIT_W-1:0];
            r_js     <= JS_START;
            r_pjw    <= '0;
        end else if (w_accept) begin
            if (i_in.last_byte) begin
                r_rs_acc <= '0;
                r_rs_mul <= RS_START[BIT_W-1:0];
                r_js     <= JS_START;
                r_pjw    <= '0;
            end else begin
                r_rs_acc <= n_rs_acc;
                r_rs_mul <= n_rs_mul;
                r_js     <= n_js;
                r_pjw    <= n_pjw;
            end
        end
    end

endmodule

/* design/bfss_queue.sv */
// Small job queue between the hash front end and the bit-store back end.
// Depends on bfss_pkg.
module bfss_queue
    import bfss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_job        = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/bfss_back.sv */
// Back end: clears the bit store after reset, then for each job reads the
// three selected words, sets the bits (insert) or checks them (query).
// Depends on bfss_pkg and bfss_out_if.
module bfss_back
    import bfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output t_back_stat  o_stat,
    bfss_out_if.source  o_out
);

    // Bit store
    logic [WORD_W-1:0] r_mem [ROWS];
    logic [WORD_W-1:0] r_rd_data;

    t_back_state       r_state, n_state;
    t_job              r_job, n_job;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [ROW_W-1:0]  r_clr_row, n_clr_row;
    logic              r_out_valid, n_out_valid;
    logic              r_out_query, n_out_query;
    logic              r_out_found, n_out_found;

    t_pos              w_pos;
    logic [ROW_W-1:0]  w_rd_row;
    logic [COL_W-1:0]  w_col;
    logic              w_bit;
    logic              w_wr_en;
    logic [ROW_W-1:0]  w_wr_row;
    logic [WORD_W-1:0] w_wr_data;

    // Current bit position
    always_comb begin
        unique case (r_idx)
            IDX_RS:  w_pos = r_job.pos[IDX_RS];
            IDX_JS:  w_pos = r_job.pos[IDX_JS];
            default: w_pos = r_job.pos[IDX_PJW];
        endcase
    end

    assign w_rd_row = w_pos[BIT_W-1:COL_W];
    assign w_col    = w_pos[COL_W-1:0];
    assign w_bit    = r_rd_data[w_col];

    // Memory ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_row] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_row];
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_out.valid     = r_out_valid;
    assign o_out.was_query = r_out_query;
    assign o_out.found     = r_out_found;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_found     = r_found;
        n_clr_row   = r_clr_row;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_query = r_out_query;
        n_out_found = r_out_found;
        o_pop       = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_row    = w_rd_row;
        w_wr_data   = r_rd_data | (WORD_W'(1) << w_col);

        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_row  = r_clr_row;
                w_wr_data = '0;
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_idx   = IDX_RS;
                    n_found = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_found = r_found && w_bit;
                w_wr_en = (r_job.cmd == CMD_INSERT);
                if (r_idx == IDX_PJW) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_query = (r_job.cmd == CMD_QUERY);
                    n_out_found = (r_job.cmd == CMD_QUERY) && r_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_idx       <= IDX_RS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_found     <= n_found;
        r_out_query <= n_out_query;
        r_out_found <= n_out_found;
    end

endmodule

/* design/bloom_filter_string_set_top.sv */
// Bloom filter over byte strings with three hashes (RS, JS, PJW).
// Top level: connects front end, job queue and bit-store back end.
// Depends on bfss_pkg, bfss_if, bfss_front, bfss_queue, bfss_back.
//
// Usage:
//   i_in carries one string byte per request (cmd, data_byte, last_byte);
//   cmd is only looked at on the byte with last_byte set: insert or query.
//   o_out carries one request per string: was_query and found.
// Throughput: one byte per cycle while i_in.ready is high. Each string end
//   costs the back end a job pickup, a read and a check for each of the three
//   bit-store words, and a result load; a four-entry job queue absorbs bursts
//   of short strings, and i_in.ready drops while it is full.
// Path: the final byte's job enters the queue, the back end picks it up, reads
//   and checks each word, then loads the result that raises o_out.valid.
// Reset: the hashes restart and the bit store is cleared one 32-bit word a
//   cycle, FILTER_BITS/32 words (512 at 16384 bits); i_in.ready stays low
//   during the clear.
// Stall: a result waits in the output register while o_out.ready is low;
//   the back end then holds its next result and the queue fills up.
module bloom_filter_string_set_top
    import bfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfss_in_if.sink     i_in,
    bfss_out_if.source  o_out
);

    logic       w_push;
    logic       w_pop;
    t_job       w_push_job;
    t_job       w_head_job;
    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;

    // Hash front end
    bfss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .i_back_stat (w_back_stat),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // Job queue
    bfss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    // Bit-store back end
    bfss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_stat   (w_back_stat),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    // No byte is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.clearing |-> !(i_in.valid && i_in.ready))
        else $error("byte accepted during bit-store clear");

    // The queue never overflows
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("job pushed into full queue");

    // The back end never takes a job from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from empty queue");

    // An insert result never reports found
    a_insert_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.was_query) |-> !o_out.found)
        else $error("insert result with found set");
`endif

endmodule
